// ----- hdl/fbc_pkg.sv -----
// Shared types and constants for the framebuffer blit format converter.
package fbc_pkg;

    // Pixel format codes
    typedef enum logic [1:0] {
        FMT_XRGB    = 2'd0,
        FMT_XBGR    = 2'd1,
        FMT_RGB565  = 2'd2,
        FMT_INVALID = 2'd3
    } fmt_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SRC_FORMAT = 3'd0,
        CFG_DST_FORMAT = 3'd1,
        CFG_SRC_WIDTH  = 3'd2,
        CFG_SRC_HEIGHT = 3'd3,
        CFG_SRC_STRIDE = 3'd4,
        CFG_DST_WIDTH  = 3'd5,
        CFG_DST_HEIGHT = 3'd6,
        CFG_DST_STRIDE = 3'd7
    } cfg_idx_t;

    localparam int unsigned DEF_MAX_DIMENSION = 4096;
    localparam int unsigned DEF_MAX_STRIDE    = 65535;

    localparam int PIXEL_W  = 32;
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 16;
    localparam int COUNT_W  = 12;
    localparam int OFFSET_W = 28;
    localparam int BYTES_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int M_FIELDS_W = PIXEL_W + BYTES_W + 2 * OFFSET_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [BYTES_W-1:0] BYTES_WIDE   = 3'd4;
    localparam logic [BYTES_W-1:0] BYTES_RGB565 = 3'd2;

endpackage

// ----- hdl/fbc_pixel_conv.sv -----
// Pixel unpack to 8-bit channels and repack into the destination format.
module fbc_pixel_conv (
    input  fbc_pkg::fmt_t                  src_fmt,
    input  fbc_pkg::fmt_t                  dst_fmt,
    input  logic [fbc_pkg::PIXEL_W-1:0]    src_pixel,
    output logic [fbc_pkg::PIXEL_W-1:0]    dst_pixel
);

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    always_comb begin
        case (src_fmt)
            fbc_pkg::FMT_XRGB: begin
                blue  = src_pixel[7:0];
                green = src_pixel[15:8];
                red   = src_pixel[23:16];
            end
            fbc_pkg::FMT_XBGR: begin
                red   = src_pixel[7:0];
                green = src_pixel[15:8];
                blue  = src_pixel[23:16];
            end
            default: begin
                // widen 565 by replicating the top bits into the low bits
                red   = {src_pixel[15:11], src_pixel[15:13]};
                green = {src_pixel[10:5], src_pixel[10:9]};
                blue  = {src_pixel[4:0], src_pixel[4:2]};
            end
        endcase
    end

    always_comb begin
        case (dst_fmt)
            fbc_pkg::FMT_XRGB: dst_pixel = {8'd0, red, green, blue};
            fbc_pkg::FMT_XBGR: dst_pixel = {8'd0, blue, green, red};
            default:           dst_pixel = {16'd0, red[7:3], green[7:2], blue[7:3]};
        endcase
    end

endmodule

// ----- hdl/framebuffer_blit_format_convert.sv -----
// Framebuffer blit with pixel format conversion: top level, stream in and out.
// The result of an accepted request is registered and shows on m_tvalid in the cycle after it is accepted.
// Throughput: one pixel per cycle; s_tready is high whenever the result register is empty
// or being drained, so dropped pixels are also taken at one per cycle.
// Synchronous reset (aresetn low) clears config registers, counters, row bases, done and valid flags.
// Any configuration write restarts the region at the first pixel.
module framebuffer_blit_format_convert #(
    parameter int unsigned MAX_DIMENSION = fbc_pkg::DEF_MAX_DIMENSION,
    parameter int unsigned MAX_STRIDE    = fbc_pkg::DEF_MAX_STRIDE
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // source pixels
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbc_pkg::PIXEL_W-1:0]       s_tdata,   // [31:0] source_pixel
    // converted pixels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] dest_pixel, [34:32] dest_byte_count, [62:35] dest_offset,
    // [90:63] source_offset, [95:91] zero
    output logic [fbc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast    // last_pixel
);

    localparam int CW = fbc_pkg::COUNT_W;
    localparam int DW = fbc_pkg::DIM_W;
    localparam int SW = fbc_pkg::STRIDE_W;
    localparam int OW = fbc_pkg::OFFSET_W;

    // configuration registers
    fbc_pkg::fmt_t   src_fmt_reg;
    fbc_pkg::fmt_t   dst_fmt_reg;
    logic [DW-1:0]   src_width_reg;
    logic [DW-1:0]   src_height_reg;
    logic [SW-1:0]   src_stride_reg;
    logic [DW-1:0]   dst_width_reg;
    logic [DW-1:0]   dst_height_reg;
    logic [SW-1:0]   dst_stride_reg;

    // traversal state
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   row_reg, row_next;
    logic [OW-1:0]   src_base_reg, src_base_next;
    logic [OW-1:0]   dst_base_reg, dst_base_next;
    logic            done_reg, done_next;

    // result register
    logic                          m_valid_reg;
    logic [fbc_pkg::PIXEL_W-1:0]   m_pixel_reg;
    logic [fbc_pkg::BYTES_W-1:0]   m_bytes_reg;
    logic [OW-1:0]                 m_dst_off_reg;
    logic [OW-1:0]                 m_src_off_reg;
    logic                          m_last_reg;

    logic            accept;
    logic            fmt_ok;
    logic [DW-1:0]   min_w, min_h, clip_w, clip_h;
    logic [SW-1:0]   clip_ss, clip_ds;
    logic            in_region, produce, run_out, end_col, is_last;
    logic [DW-1:0]   col_ext, row_ext;
    logic [OW-1:0]   src_col_off, dst_col_off;
    logic [fbc_pkg::BYTES_W-1:0]   dst_bytes;
    logic [fbc_pkg::PIXEL_W-1:0]   conv_pixel;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_valid_reg || m_tready;

    assign fmt_ok = (src_fmt_reg != fbc_pkg::FMT_INVALID)
                 && (dst_fmt_reg != fbc_pkg::FMT_INVALID)
                 && (src_stride_reg != '0) && (dst_stride_reg != '0);

    assign min_w  = (src_width_reg < dst_width_reg) ? src_width_reg : dst_width_reg;
    assign min_h  = (src_height_reg < dst_height_reg) ? src_height_reg : dst_height_reg;
    assign clip_w = ({19'd0, min_w} > 32'(MAX_DIMENSION)) ? MAX_DIMENSION[DW-1:0] : min_w;
    assign clip_h = ({19'd0, min_h} > 32'(MAX_DIMENSION)) ? MAX_DIMENSION[DW-1:0] : min_h;
    assign clip_ss = ({16'd0, src_stride_reg} > 32'(MAX_STRIDE))
                   ? MAX_STRIDE[SW-1:0] : src_stride_reg;
    assign clip_ds = ({16'd0, dst_stride_reg} > 32'(MAX_STRIDE))
                   ? MAX_STRIDE[SW-1:0] : dst_stride_reg;

    assign col_ext   = {1'b0, col_reg};
    assign row_ext   = {1'b0, row_reg};
    assign in_region = (col_ext < clip_w) && (row_ext < clip_h);
    assign produce   = fmt_ok && !done_reg && in_region;
    // position past the region: mark done, no result
    assign run_out   = fmt_ok && !done_reg && (clip_w != '0) && (clip_h != '0) && !in_region;
    assign end_col   = col_ext == (clip_w - DW'(1));
    assign is_last   = end_col && (row_ext == (clip_h - DW'(1)));

    assign src_col_off = (src_fmt_reg == fbc_pkg::FMT_RGB565)
                       ? {15'd0, col_reg, 1'b0} : {14'd0, col_reg, 2'b00};
    assign dst_col_off = (dst_fmt_reg == fbc_pkg::FMT_RGB565)
                       ? {15'd0, col_reg, 1'b0} : {14'd0, col_reg, 2'b00};
    assign dst_bytes   = (dst_fmt_reg == fbc_pkg::FMT_RGB565)
                       ? fbc_pkg::BYTES_RGB565 : fbc_pkg::BYTES_WIDE;

    fbc_pixel_conv u_conv (
        .src_fmt   (src_fmt_reg),
        .dst_fmt   (dst_fmt_reg),
        .src_pixel (s_tdata),
        .dst_pixel (conv_pixel)
    );

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        done_next     = done_reg;
        if (cfg_wr_en) begin
            // any write restarts the region
            col_next      = '0;
            row_next      = '0;
            src_base_next = '0;
            dst_base_next = '0;
            done_next     = 1'b0;
        end else if (accept && produce) begin
            if (is_last) begin
                done_next = 1'b1;
            end else if (end_col) begin
                col_next      = '0;
                row_next      = row_reg + CW'(1);
                src_base_next = src_base_reg + {12'd0, clip_ss};
                dst_base_next = dst_base_reg + {12'd0, clip_ds};
            end else begin
                col_next = col_reg + CW'(1);
            end
        end else if (accept && run_out) begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg    <= fbc_pkg::FMT_XRGB;
            dst_fmt_reg    <= fbc_pkg::FMT_XRGB;
            src_width_reg  <= '0;
            src_height_reg <= '0;
            src_stride_reg <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
            dst_stride_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (fbc_pkg::cfg_idx_t'(cfg_addr))
                fbc_pkg::CFG_SRC_FORMAT: src_fmt_reg    <= fbc_pkg::fmt_t'(cfg_wdata[1:0]);
                fbc_pkg::CFG_DST_FORMAT: dst_fmt_reg    <= fbc_pkg::fmt_t'(cfg_wdata[1:0]);
                fbc_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[DW-1:0];
                fbc_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata[DW-1:0];
                fbc_pkg::CFG_SRC_STRIDE: src_stride_reg <= cfg_wdata[SW-1:0];
                fbc_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[DW-1:0];
                fbc_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_wdata[DW-1:0];
                fbc_pkg::CFG_DST_STRIDE: dst_stride_reg <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            src_base_reg <= '0;
            dst_base_reg <= '0;
            done_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            src_base_reg <= src_base_next;
            dst_base_reg <= dst_base_next;
            done_reg     <= done_next;
            if (s_tready) begin
                m_valid_reg <= accept && produce;
            end
        end
    end

    // load the result payload only when a request yields a pixel
    always_ff @(posedge aclk) begin
        if (accept && produce) begin
            m_pixel_reg   <= conv_pixel;
            m_bytes_reg   <= dst_bytes;
            m_dst_off_reg <= dst_base_reg + dst_col_off;
            m_src_off_reg <= src_base_reg + src_col_off;
            m_last_reg    <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(fbc_pkg::M_TDATA_W - fbc_pkg::M_FIELDS_W){1'b0}},
                       m_src_off_reg, m_dst_off_reg, m_bytes_reg, m_pixel_reg};

endmodule
